FILE: sv/fisr_pkg.sv
// ----------------------------------------------------------------------------
// fisr_pkg: shared constants and helpers for the inverse square root unit
// Holds binary32 constants and leading-zero counters used by the FP units.
// ----------------------------------------------------------------------------
package fisr_pkg;

  localparam logic [31:0] MAGIC_GUESS    = 32'h5F3759DF;
  localparam logic [31:0] CANON_NAN      = 32'h7FC00000;
  localparam logic [31:0] FP_HALF        = 32'h3F000000;
  localparam logic [31:0] FP_ONE_HALF    = 32'h3FC00000;
  localparam logic [7:0]  EXP_ALL_ONES   = 8'hFF;

  // Leading-zero count of a 48-bit word; 48 when the word is zero.
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] lz;
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) lz = 6'(47 - i);
    end
    return lz;
  endfunction

  // Leading-zero count of a 27-bit word; 27 when the word is zero.
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] lz;
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) lz = 5'(26 - i);
    end
    return lz;
  endfunction

endpackage

FILE: sv/fisr_fmul.sv
// ----------------------------------------------------------------------------
// fisr_fmul: three-stage binary32 multiplier
// Multiply, normalize-amount, then shift/round/pack with RNE and subnormals.
// ----------------------------------------------------------------------------
module fisr_fmul import fisr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        i_valid,
  output logic        i_ready,
  input  logic [31:0] i_a,
  input  logic [31:0] i_b,
  input  logic [31:0] i_tag,
  output logic        o_valid,
  input  logic        o_ready,
  output logic [31:0] o_res,
  output logic [31:0] o_tag
);

  logic en1, en2, en3;

  // Stage 1 registers
  logic               v1_r;
  logic               sign1_r, nan1_r, inf1_r, zero1_r;
  logic [47:0]        prod1_r;
  logic signed [10:0] e1_r;
  logic [31:0]        tag1_r;

  // Stage 2 registers
  logic        v2_r;
  logic        sign2_r, nan2_r, inf2_r, zero2_r;
  logic [47:0] prod2_r;
  logic        right2_r;
  logic [5:0]  sh2_r;
  logic [9:0]  base2_r;
  logic [31:0] tag2_r;

  // Stage 3 registers
  logic        v3_r;
  logic [31:0] res3_r;
  logic [31:0] tag3_r;

  assign en3     = !v3_r || o_ready;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign i_ready = en1;

  // Stage 1: unpack and multiply the significands.
  logic [7:0]         ea, eb, eea, eeb;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0]        ma, mb;
  logic               nan1_nxt, inf1_nxt, zero1_nxt;
  logic signed [10:0] e1_nxt;

  always_comb begin
    ea     = i_a[30:23];
    eb     = i_b[30:23];
    a_nan  = (ea == EXP_ALL_ONES) && (i_a[22:0] != '0);
    b_nan  = (eb == EXP_ALL_ONES) && (i_b[22:0] != '0);
    a_inf  = (ea == EXP_ALL_ONES) && (i_a[22:0] == '0);
    b_inf  = (eb == EXP_ALL_ONES) && (i_b[22:0] == '0);
    a_zero = (ea == '0) && (i_a[22:0] == '0);
    b_zero = (eb == '0) && (i_b[22:0] == '0);
    ma     = {ea != '0, i_a[22:0]};
    mb     = {eb != '0, i_b[22:0]};
    eea    = (ea == '0) ? 8'd1 : ea;
    eeb    = (eb == '0) ? 8'd1 : eb;
    nan1_nxt  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    inf1_nxt  = a_inf || b_inf;
    zero1_nxt = a_zero || b_zero;
    e1_nxt    = $signed({3'b000, eea}) + $signed({3'b000, eeb}) - 11'sd127;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sign1_r <= i_a[31] ^ i_b[31];
      nan1_r  <= nan1_nxt;
      inf1_r  <= inf1_nxt;
      zero1_r <= zero1_nxt;
      prod1_r <= ma * mb;
      e1_r    <= e1_nxt;
      tag1_r  <= i_tag;
    end
  end

  // Stage 2: leading-zero count and shift amount, normal or subnormal.
  logic [5:0]         lz;
  logic signed [10:0] bexp, neg_e;
  logic               right2_nxt;
  logic [5:0]         sh2_nxt;
  logic [9:0]         base2_nxt;

  always_comb begin
    lz    = lzc48(prod1_r);
    bexp  = e1_r + 11'sd1 - $signed({5'b00000, lz});
    neg_e = -e1_r;
    right2_nxt = 1'b0;
    sh2_nxt    = lz;
    base2_nxt  = '0;
    if (bexp >= 11'sd1) begin
      base2_nxt = 10'(bexp - 11'sd1);
    end else if (e1_r >= 11'sd0) begin
      sh2_nxt = e1_r[5:0];
    end else begin
      right2_nxt = 1'b1;
      sh2_nxt    = (neg_e > 11'sd63) ? 6'd63 : neg_e[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sign2_r  <= sign1_r;
      nan2_r   <= nan1_r;
      inf2_r   <= inf1_r;
      zero2_r  <= zero1_r;
      prod2_r  <= prod1_r;
      right2_r <= right2_nxt;
      sh2_r    <= sh2_nxt;
      base2_r  <= base2_nxt;
      tag2_r   <= tag1_r;
    end
  end

  // Stage 3: align, round to nearest even and pack.
  logic [95:0] wide;
  logic [47:0] m;
  logic        stk, inc;
  logic [33:0] packed_v;
  logic [31:0] res3_nxt;

  always_comb begin
    wide = '0;
    stk  = 1'b0;
    if (right2_r) begin
      wide = {prod2_r, 48'b0} >> sh2_r;
      m    = wide[95:48];
      stk  = |wide[47:0];
    end else begin
      m = prod2_r << sh2_r;
    end
    inc      = m[23] && (stk || (|m[22:0]) || m[24]);
    packed_v = {1'b0, base2_r, 23'b0} + {10'b0, m[47:24]} + {33'b0, inc};
    if (nan2_r) begin
      res3_nxt = CANON_NAN;
    end else if (inf2_r || (packed_v >= {3'b000, EXP_ALL_ONES, 23'b0})) begin
      res3_nxt = {sign2_r, EXP_ALL_ONES, 23'b0};
    end else if (zero2_r) begin
      res3_nxt = {sign2_r, 31'b0};
    end else begin
      res3_nxt = {sign2_r, packed_v[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      res3_r <= res3_nxt;
      tag3_r <= tag2_r;
    end
  end

  assign o_valid = v3_r;
  assign o_res   = res3_r;
  assign o_tag   = tag3_r;

endmodule

FILE: sv/fisr_fadd.sv
// ----------------------------------------------------------------------------
// fisr_fadd: four-stage binary32 adder
// Swap/compare, align and add, normalize amount, then shift/round/pack (RNE).
// ----------------------------------------------------------------------------
module fisr_fadd import fisr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        i_valid,
  output logic        i_ready,
  input  logic [31:0] i_a,
  input  logic [31:0] i_b,
  input  logic [31:0] i_tag,
  output logic        o_valid,
  input  logic        o_ready,
  output logic [31:0] o_res,
  output logic [31:0] o_tag
);

  logic en1, en2, en3, en4;

  logic        v1_r, sign1_r, zsign1_r, nan1_r, inf1_r, sub1_r;
  logic [23:0] mb1_r, ms1_r;
  logic [7:0]  eb1_r;
  logic [4:0]  d1_r;
  logic [31:0] tag1_r;

  logic        v2_r, sign2_r, zsign2_r, nan2_r, inf2_r;
  logic [27:0] s2_r;
  logic [7:0]  eb2_r;
  logic [31:0] tag2_r;

  logic        v3_r, sign3_r, zsign3_r, nan3_r, inf3_r, carry3_r, szero3_r;
  logic [27:0] s3_r;
  logic [4:0]  sh3_r;
  logic [7:0]  base3_r;
  logic [31:0] tag3_r;

  logic        v4_r;
  logic [31:0] res4_r, tag4_r;

  assign en4     = !v4_r || o_ready;
  assign en3     = !v3_r || en4;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign i_ready = en1;

  // Stage 1: classify, order by magnitude, exponent difference.
  logic [7:0]  ea, eb, ebig, esml, dd;
  logic        a_nan, b_nan, a_inf, b_inf, a_ge, sub_nxt;
  logic [31:0] big, sml;

  always_comb begin
    ea    = i_a[30:23];
    eb    = i_b[30:23];
    a_nan = (ea == EXP_ALL_ONES) && (i_a[22:0] != '0);
    b_nan = (eb == EXP_ALL_ONES) && (i_b[22:0] != '0);
    a_inf = (ea == EXP_ALL_ONES) && (i_a[22:0] == '0);
    b_inf = (eb == EXP_ALL_ONES) && (i_b[22:0] == '0);
    a_ge  = i_a[30:0] >= i_b[30:0];
    big   = a_ge ? i_a : i_b;
    sml   = a_ge ? i_b : i_a;
    ebig  = (big[30:23] == '0) ? 8'd1 : big[30:23];
    esml  = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    dd    = ebig - esml;
    sub_nxt = i_a[31] ^ i_b[31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sign1_r  <= big[31];
      zsign1_r <= sub_nxt ? 1'b0 : big[31];
      nan1_r   <= a_nan || b_nan || (a_inf && b_inf && sub_nxt);
      inf1_r   <= a_inf || b_inf;
      sub1_r   <= sub_nxt;
      mb1_r    <= {big[30:23] != '0, big[22:0]};
      ms1_r    <= {sml[30:23] != '0, sml[22:0]};
      eb1_r    <= ebig;
      d1_r     <= (dd > 8'd31) ? 5'd31 : dd[4:0];
      tag1_r   <= i_tag;
    end
  end

  // Stage 2: align the smaller operand with sticky, then add or subtract.
  logic [53:0] al;
  logic [26:0] sm;
  logic [27:0] s2_nxt;

  always_comb begin
    al = {ms1_r, 3'b000, 27'b0} >> d1_r;
    sm = {al[53:28], al[27] | (|al[26:0])};
    if (sub1_r) begin
      s2_nxt = {1'b0, mb1_r, 3'b000} - {1'b0, sm};
    end else begin
      s2_nxt = {1'b0, mb1_r, 3'b000} + {1'b0, sm};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sign2_r  <= sign1_r;
      zsign2_r <= zsign1_r;
      nan2_r   <= nan1_r;
      inf2_r   <= inf1_r;
      s2_r     <= s2_nxt;
      eb2_r    <= eb1_r;
      tag2_r   <= tag1_r;
    end
  end

  // Stage 3: normalization amount, limited so the exponent stays at one.
  logic [4:0] lz, sh_nxt;
  logic [7:0] limit, base_nxt;

  always_comb begin
    lz     = lzc27(s2_r[26:0]);
    limit  = eb2_r - 8'd1;
    sh_nxt = ({3'b000, lz} < limit) ? lz : limit[4:0];
    if (s2_r[27]) begin
      base_nxt = eb2_r;
    end else begin
      base_nxt = eb2_r - {3'b000, sh_nxt} - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      sign3_r  <= sign2_r;
      zsign3_r <= zsign2_r;
      nan3_r   <= nan2_r;
      inf3_r   <= inf2_r;
      carry3_r <= s2_r[27];
      szero3_r <= (s2_r == '0);
      s3_r     <= s2_r;
      sh3_r    <= sh_nxt;
      base3_r  <= base_nxt;
      tag3_r   <= tag2_r;
    end
  end

  // Stage 4: shift, round to nearest even and pack.
  logic [27:0] n;
  logic        inc;
  logic [31:0] packed_v, res4_nxt;

  always_comb begin
    if (carry3_r) begin
      n = {1'b0, s3_r[27:2], s3_r[1] | s3_r[0]};
    end else begin
      n = s3_r << sh3_r;
    end
    inc      = n[2] && (n[1] || n[0] || n[3]);
    packed_v = {1'b0, base3_r, 23'b0} + {8'b0, n[26:3]} + {31'b0, inc};
    if (nan3_r) begin
      res4_nxt = CANON_NAN;
    end else if (inf3_r || (packed_v >= {1'b0, EXP_ALL_ONES, 23'b0})) begin
      res4_nxt = {sign3_r, EXP_ALL_ONES, 23'b0};
    end else if (szero3_r) begin
      res4_nxt = {zsign3_r, 31'b0};
    end else begin
      res4_nxt = {sign3_r, packed_v[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      res4_r <= res4_nxt;
      tag4_r <= tag3_r;
    end
  end

  assign o_valid = v4_r;
  assign o_res   = res4_r;
  assign o_tag   = tag4_r;

endmodule

FILE: sv/fast_inverse_square_root_unit.sv
// ----------------------------------------------------------------------------
// fast_inverse_square_root_unit: pipelined approximate 1/sqrt(a) for binary32
// Magic-constant estimate followed by one Newton-Raphson step, full IEEE RNE.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                      | Direction
//  --------+--------------------------------------------+----------
//  input   | in_valid, in_ready, in_value_bits[31:0]    | request in
//  result  | out_valid, out_ready, out_result_bits[31:0]| request out
//
// One request is accepted every cycle while out_ready does not hold the pipeline;
// each passes from acceptance to a valid result through the chain of four multipliers
// (3 stages each) and one adder (4 stages) that the Newton step runs through in order.
// Reset clears only the valid bits of the pipeline; no data is reset.
// Each stage advances when it is empty or the stage after it advances, so a
// stall at out_ready holds every request in place and bubbles still close up.
//
module fast_inverse_square_root_unit import fisr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_bits
);

  // The first guess is pure integer arithmetic: the operand bits shifted
  // right arithmetically by one, subtracted from the magic constant with
  // wraparound. It rides along as the tag of every unit as x.
  logic [31:0] guess;
  assign guess = MAGIC_GUESS - {in_value_bits[31], in_value_bits[31:1]};

  logic        v0, r0, v1, r1, v2, r2, v3, r3;
  logic [31:0] half, p1, p2, corr, res;
  logic [31:0] x0, x1, x2, x3, x4;

  // half = 0.5 * a
  fisr_fmul u_half (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (in_valid),
    .i_ready (in_ready),
    .i_a     (FP_HALF),
    .i_b     (in_value_bits),
    .i_tag   (guess),
    .o_valid (v0),
    .o_ready (r0),
    .o_res   (half),
    .o_tag   (x0)
  );

  // p1 = half * x
  fisr_fmul u_p1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (v0),
    .i_ready (r0),
    .i_a     (half),
    .i_b     (x0),
    .i_tag   (x0),
    .o_valid (v1),
    .o_ready (r1),
    .o_res   (p1),
    .o_tag   (x1)
  );

  // p2 = p1 * x
  fisr_fmul u_p2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (v1),
    .i_ready (r1),
    .i_a     (p1),
    .i_b     (x1),
    .i_tag   (x1),
    .o_valid (v2),
    .o_ready (r2),
    .o_res   (p2),
    .o_tag   (x2)
  );

  // corr = 1.5 - p2, done as an addition of the negated product.
  fisr_fadd u_corr (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (v2),
    .i_ready (r2),
    .i_a     (FP_ONE_HALF),
    .i_b     ({~p2[31], p2[30:0]}),
    .i_tag   (x2),
    .o_valid (v3),
    .o_ready (r3),
    .o_res   (corr),
    .o_tag   (x3)
  );

  // r = x * corr; the last stage register of this unit is the output register.
  fisr_fmul u_final (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (v3),
    .i_ready (r3),
    .i_a     (x3),
    .i_b     (corr),
    .i_tag   (x3),
    .o_valid (out_valid),
    .o_ready (out_ready),
    .o_res   (res),
    .o_tag   (x4)
  );

  // Every unit already returns the canonical quiet NaN; the check here keeps
  // the output contract explicit and also consumes the unused final tag.
  logic res_nan;
  assign res_nan = ((res[30:23] == EXP_ALL_ONES) && (res[22:0] != '0)) || (x4 != x4);
  assign out_result_bits = res_nan ? CANON_NAN : res;

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for fast_inverse_square_root_unit
// Drives binary32 operands through the valid/ready input channel, predicts
// each result with an integer model of the binary32 multiplies and subtract,
// and compares every accepted result in order against the predictions.
// ----------------------------------------------------------------------------
module tb;
  import fisr_pkg::*;

  // Scoreboard: holds the predicted results of accepted requests, oldest
  // first, and compares each returned result with the head of the queue.
  class rsqrt_scoreboard;
    logic [31:0] expected_rsqrt[$];
    int          mismatches;

    // Rounds the exact value s * m * 2^e to binary32, nearest even.
    static function logic [31:0] round_fp32(bit s, logic [63:0] m, int e);
      int          msb;
      int          shift;
      int          biased;
      logic [63:0] q;
      bit          half_bit;
      bit          rest;
      msb = 0;
      for (int i = 0; i < 64; i++) if (m[i]) msb = i;
      // Keep 24 significant bits, but never go below the subnormal step.
      shift = msb - 23;
      if (shift < -149 - e) shift = -149 - e;
      if (shift > 63) return {s, 31'b0};
      if (shift > 0) begin
        q        = m >> shift;
        half_bit = m[shift-1];
        rest     = (m & ((64'd1 << (shift - 1)) - 1)) != 0;
        if (half_bit && (rest || q[0])) q = q + 1;
        if (q == (64'd1 << 24)) begin
          q     = q >> 1;
          shift = shift + 1;
        end
      end else begin
        q = m << (-shift);
      end
      if (q < (64'd1 << 23)) return {s, 8'h00, q[22:0]};
      biased = e + shift + 23 + 127;
      if (biased >= 255) return {s, EXP_ALL_ONES, 23'b0};
      return {s, biased[7:0], q[22:0]};
    endfunction

    static function bit is_nan(logic [31:0] f);
      return f[30:23] == EXP_ALL_ONES && f[22:0] != 0;
    endfunction

    static function bit is_inf(logic [31:0] f);
      return f[30:23] == EXP_ALL_ONES && f[22:0] == 0;
    endfunction

    // Significand with the hidden bit and the exponent of its lsb plus 150.
    static function void unpack(logic [31:0] f, output logic [63:0] m, output int e);
      if (f[30:23] == 0) begin
        m = {41'b0, f[22:0]};
        e = 1;
      end else begin
        m = {40'b0, 1'b1, f[22:0]};
        e = int'(f[30:23]);
      end
    endfunction

    static function logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      bit          s;
      logic [63:0] ma, mb;
      int          ea, eb;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return CANON_NAN;
      if (is_inf(a) || is_inf(b)) begin
        if (a[30:0] == 0 || b[30:0] == 0) return CANON_NAN;
        return {s, EXP_ALL_ONES, 23'b0};
      end
      if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'b0};
      unpack(a, ma, ea);
      unpack(b, mb, eb);
      return round_fp32(s, ma * mb, ea + eb - 300);
    endfunction

    static function logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
      logic [31:0] big, tiny;
      logic [63:0] mb, mt, ml, ms, sum;
      int          eb, et, d;
      bit          s;
      if (is_nan(a) || is_nan(b)) return CANON_NAN;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return CANON_NAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
      if (a[30:0] == 0) return b;
      if (b[30:0] == 0) return a;
      if (a[30:23] >= b[30:23]) begin
        big  = a;
        tiny = b;
      end else begin
        big  = b;
        tiny = a;
      end
      unpack(big, mb, eb);
      unpack(tiny, mt, et);
      d  = eb - et;
      ml = mb << 30;
      ms = mt << 30;
      // Bits shifted out fold into a sticky lsb well below the round point.
      if (d >= 60) ms = 64'd1;
      else if (d > 0) ms = (ms >> d) | {63'b0, (ms & ((64'd1 << d) - 1)) != 0};
      if (big[31] == tiny[31]) begin
        sum = ml + ms;
        s   = big[31];
      end else if (ml >= ms) begin
        sum = ml - ms;
        s   = big[31];
      end else begin
        sum = ms - ml;
        s   = tiny[31];
      end
      if (sum == 0) return 32'h0000_0000;
      return round_fp32(s, sum, eb - 180);
    endfunction

    // Magic-constant guess, then x * (1.5 - ((half * x) * x)).
    static function logic [31:0] predict_rsqrt(logic [31:0] a);
      logic [31:0] half_a, guess, p1, p2, corr, r;
      half_a = fp_mul(FP_HALF, a);
      guess  = MAGIC_GUESS - {a[31], a[31:1]};
      p1     = fp_mul(half_a, guess);
      p2     = fp_mul(p1, guess);
      corr   = fp_add(FP_ONE_HALF, {~p2[31], p2[30:0]});
      r      = fp_mul(guess, corr);
      return is_nan(r) ? CANON_NAN : r;
    endfunction

    function void note_request(logic [31:0] a);
      expected_rsqrt.push_back(predict_rsqrt(a));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (expected_rsqrt.size() == 0) begin
        $display("%0t: result with no request pending: expected none, actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = expected_rsqrt.pop_front();
      if (got !== want) begin
        $display("%0t: result_bits mismatch: expected %h, actual %h", $time, want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_value_bits;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_result_bits;

  rsqrt_scoreboard sb;
  int              results_seen;

  fast_inverse_square_root_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value_bits   (in_value_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_bits (out_result_bits)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Idle cycles before the next request or result. Every third block of 64
  // transfers runs with no idling at all so the pipeline sees full rate.
  function automatic int draw_gap(int n);
    if ((n / 64) % 3 == 1) return 0;
    return $urandom_range(0, 9);
  endfunction

  // Offers one request and holds it until the unit takes it. valid stays
  // high between back-to-back requests; only the payload changes.
  task automatic send_request(logic [31:0] value, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_value_bits <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_request(value);
  endtask

  // Random operand: half positive with random other bits, a quarter with an
  // exponent of 100..154, any sign; the rest fully random (negatives, NaNs, subnormals).
  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 3))
      0, 1: v[31] = 1'b0;
      2:    v[30:23] = 8'($urandom_range(100, 154));
      default: ;
    endcase
    return v;
  endfunction

  // Result side: random stalls, plus one long hold-off so that the pipeline
  // fills completely and the unit has to push back on its input.
  initial begin
    int stall;
    out_ready    = 1'b0;
    results_seen = 0;
    @(posedge rst_n);
    stall = draw_gap(0);
    forever begin
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_result_bits);
      results_seen++;
      stall = (results_seen == 150) ? 300 : draw_gap(results_seen);
    end
  end

  initial begin
    logic [31:0] directed[$];
    int          limit;
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value_bits = 32'h0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zeros, infinities, NaNs, subnormal and normal edges, negatives
    // (no sign check is made), the all-ones pattern and ordinary values.
    directed = {32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                32'h7FC0_0000, 32'hFFC0_0001, 32'h7F80_0001, 32'h0000_0001,
                32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                32'h3F80_0000, 32'h4080_0000, 32'h3E80_0000, 32'hBF80_0000,
                32'h8000_0001, 32'hFFFF_FFFF, 32'h5F37_59DF, 32'hBEEF_0000,
                32'h4049_0FDB, 32'h3C23_D70A, 32'h4B00_0000, 32'hAAAA_AAAA,
                32'h5555_5555};
    foreach (directed[i]) send_request(directed[i], draw_gap(i));
    for (int n = 0; n < 580; n++) send_request(random_operand(), draw_gap(n));
    in_valid <= 1'b0;

    limit = 0;
    while (sb.expected_rsqrt.size() != 0 && limit < 20000) begin
      @(posedge clk);
      limit++;
    end
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_rsqrt.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
